[rtl/core/swm_pkg.sv]
// Shared constants, types and helpers for the sliding window median filter.
`default_nettype none

package swm_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int DATA_W     = 32;
   localparam int IDX_W      = $clog2(WINDOW_MAX);
   localparam int CNT_W      = IDX_W + 1;
   localparam int AGE_W      = IDX_W;

   typedef logic signed [DATA_W-1:0] sample_type;

   // State one cell shows to its neighbors
   typedef struct packed {
      logic               valid;
      logic               gt;     // entry is greater than the incoming sample (or empty)
      logic [AGE_W-1:0]   age;
      sample_type         value;
   } cell_data_type;

   // Control broadcast to every cell of the chain
   typedef struct packed {
      logic               upd;     // a sample transfer updates the chain
      logic               full;    // window full before this update
      logic               clr;     // empty the window
      logic [IDX_W-1:0]   win_m1;  // effective window size minus one
      sample_type         sample;
   } cell_ctl_type;

   // Bit i set when any bit below i is set in hit
   function automatic logic [WINDOW_MAX-1:0] prefix_below(input logic [WINDOW_MAX-1:0] hit);
      logic [WINDOW_MAX-1:0] acc;
      acc = hit << 1;
      for (int s = 1; s < WINDOW_MAX; s = s * 2) begin
         acc = acc | (acc << s);
      end
      return acc;
   endfunction

   // Window size register to size-minus-one, zero taken as one, saturated at the max
   function automatic logic [IDX_W-1:0] clamp_win_m1(input logic [CNT_W-1:0] size);
      logic [IDX_W-1:0] res;
      if (size == '0) begin
         res = '0;
      end else if (size > CNT_W'(WINDOW_MAX)) begin
         res = IDX_W'(WINDOW_MAX - 1);
      end else begin
         res = IDX_W'(size - 1'b1);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[rtl/core/swm_cell.sv]
// One sorting cell: holds one window entry and its age, trades with its neighbors.
`default_nettype none

module swm_cell import swm_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctl_type  ctl,
   input  wire cell_data_type left,
   input  wire cell_data_type right,
   input  wire logic          evict_lt,  // the evicted entry sits below this cell
   output cell_data_type      own,
   output logic               evict
);

   logic             valid_ff, valid_in;
   sample_type       value_ff, value_in;
   logic [AGE_W-1:0] age_ff, age_in;
   logic             gt;

   assign gt    = !valid_ff || (value_ff > ctl.sample);
   assign evict = ctl.full && valid_ff && (age_ff == ctl.win_m1);

   always_comb begin
      own.valid = valid_ff;
      own.gt    = gt;
      own.age   = age_ff;
      own.value = value_ff;
   end

   // Next entry: shift right above the insertion point, shift left above the eviction
   always_comb begin
      value_in = value_ff;
      age_in   = age_ff + 1'b1;
      if (evict_lt) begin
         if (!right.gt) begin
            value_in = right.value;
            age_in   = right.age + 1'b1;
         end else if (!gt) begin
            value_in = ctl.sample;
            age_in   = '0;
         end
      end else if (evict) begin
         if (left.gt) begin
            value_in = left.value;
            age_in   = left.age + 1'b1;
         end else if (right.gt) begin
            value_in = ctl.sample;
            age_in   = '0;
         end else begin
            value_in = right.value;
            age_in   = right.age + 1'b1;
         end
      end else begin
         if (left.gt) begin
            value_in = left.value;
            age_in   = left.age + 1'b1;
         end else if (gt) begin
            value_in = ctl.sample;
            age_in   = '0;
         end
      end
   end

   // Occupancy grows by one from the bottom until the window is full; clr empties it
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clr) begin
         valid_in = 1'b0;
      end else if (ctl.upd && !ctl.full) begin
         valid_in = left.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.upd) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/sliding_window_median.sv]
// A sample transfer updates the cell chain and read-pending flag, then the median register.
// One sample per cycle unless stalled; the sorting cell chain inserts and evicts together.
// A full cell chain is read at the median rank after its update, once the output is free.
// The first window_size-1 samples after reset or a window_size write give no result.
// Reset empties the window and sets window_size to 3; no clearing pass is needed.
`default_nettype none

module sliding_window_median import swm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic signed [31:0] req_sample,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic signed [31:0]     rsp_median,
   input  wire logic              csr_wr_en,
   input  wire logic [6:0]        csr_wr_data
);

   localparam cell_data_type EDGE_LEFT  = '{valid: 1'b1, gt: 1'b0, age: '0, value: '0};
   localparam cell_data_type EDGE_RIGHT = '{valid: 1'b0, gt: 1'b1, age: '0, value: '0};

   logic [IDX_W-1:0]      win_m1_ff, win_m1_in;
   logic [IDX_W-1:0]      rank_ff, rank_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sample_type            rsp_median_ff;

   cell_ctl_type          ctl;
   cell_data_type         chain [WINDOW_MAX+2];
   sample_type            cell_vals [WINDOW_MAX];
   logic [WINDOW_MAX-1:0] valid_vec;
   logic [WINDOW_MAX-1:0] evict_vec;
   logic [WINDOW_MAX-1:0] evict_lt_vec;
   logic                  upd, full, emit, rd_move;

   // Handshake: hold off a transfer only when a finished median cannot leave
   assign rd_move   = rd_pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = rd_pend_ff && rsp_valid_ff && rsp_stall;
   assign upd       = req_valid && !req_stall;
   assign full      = valid_vec[win_m1_ff];
   assign emit      = full || (win_m1_ff == '0) || valid_vec[win_m1_ff - 1'b1];

   always_comb begin
      ctl.upd    = upd;
      ctl.full   = full;
      ctl.clr    = csr_wr_en;
      ctl.win_m1 = win_m1_ff;
      ctl.sample = req_sample;
   end

   assign chain[0]            = EDGE_LEFT;
   assign chain[WINDOW_MAX+1] = EDGE_RIGHT;
   assign evict_lt_vec        = prefix_below(evict_vec);

   // Cell chain
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .left     (chain[i]),
         .right    (chain[i+2]),
         .evict_lt (evict_lt_vec[i]),
         .own      (chain[i+1]),
         .evict    (evict_vec[i])
      );
      assign valid_vec[i] = chain[i+1].valid;
      assign cell_vals[i] = chain[i+1].value;
   end

   // Window size and median rank registers
   always_comb begin
      win_m1_in = win_m1_ff;
      rank_in   = rank_ff;
      if (csr_wr_en) begin
         win_m1_in = clamp_win_m1(csr_wr_data);
         rank_in   = clamp_win_m1(csr_wr_data) >> 1;
      end
   end

   // Median read stage and output register
   always_comb begin
      rd_pend_in = rd_pend_ff;
      if (upd) begin
         rd_pend_in = emit;
      end else if (rd_move) begin
         rd_pend_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rd_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_m1_ff    <= IDX_W'(2);
         rank_ff      <= IDX_W'(1);
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_m1_ff    <= win_m1_in;
         rank_ff      <= rank_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_move) begin
         rsp_median_ff <= cell_vals[rank_ff];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

   // Checks
   a_evict_onehot0: assert property (@(posedge clock) disable iff (reset)
      $onehot0(evict_vec))
      else $error("more than one entry marked oldest");

   a_evict_when_full: assert property (@(posedge clock) disable iff (reset)
      upd && full |-> $onehot(evict_vec))
      else $error("full window without an oldest entry");

   a_valid_thermo: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + 1'b1) & valid_vec) == '0)
      else $error("occupied cells not contiguous from the bottom");

   a_count_at_emit: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> $countones(valid_vec) == (32'(win_m1_ff) + 1))
      else $error("median read from a window that is not full");

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Testbench for the sliding window median filter: directed and random samples, self-checking.
`timescale 1ns / 1ps

module tb_top;
   import swm_pkg::*;

   // Running-median predictor and the queue of medians still due from the block
   class median_scoreboard;
      logic [6:0]       win_reg;
      sample_type       vals [WINDOW_MAX];
      logic [AGE_W-1:0] ages [WINDOW_MAX];
      int unsigned      fill;
      sample_type       medians_due [$];
      int unsigned      fails;

      function new();
         win_reg = 7'd3;
         fill    = 0;
         fails   = 0;
      endfunction

      // A window_size write empties the window
      function void set_window(logic [6:0] v);
         win_reg = v;
         fill    = 0;
      endfunction

      // Zero counts as one, large sizes saturate
      function int unsigned span();
         if (win_reg == 7'd0) begin
            return 1;
         end else if (win_reg > 7'(WINDOW_MAX)) begin
            return WINDOW_MAX;
         end
         return win_reg;
      endfunction

      function int unsigned pending();
         return medians_due.size();
      endfunction

      // Accepted sample transfer: evict the oldest, age, insert, maybe owe a median
      function void take_sample(sample_type s);
         int unsigned      w;
         int unsigned      i;
         int unsigned      pos;
         logic [AGE_W-1:0] top_age;
         w = span();
         if (fill > w) fill = w;
         if (fill == w && fill > 0) begin
            pos     = 0;
            top_age = '0;
            // the last entry with the largest age is the oldest
            for (i = 0; i < fill; i++) begin
               if (ages[i] >= top_age) begin
                  top_age = ages[i];
                  pos     = i;
               end
            end
            for (i = pos; i + 1 < fill; i++) begin
               vals[i] = vals[i+1];
               ages[i] = ages[i+1];
            end
            fill--;
         end
         for (i = 0; i < fill; i++) ages[i] = ages[i] + 1'b1;
         // equal samples land after the existing ones
         pos = fill;
         while (pos > 0 && vals[pos-1] > s) begin
            vals[pos] = vals[pos-1];
            ages[pos] = ages[pos-1];
            pos--;
         end
         vals[pos] = s;
         ages[pos] = '0;
         fill++;
         if (fill == w) medians_due.push_back(vals[(w + 1) / 2 - 1]);
      endfunction

      // Accepted result transfer against the oldest expected median
      function void check_median(sample_type got);
         sample_type want;
         if (medians_due.size() == 0) begin
            $display("%0t: unexpected median, expected none, actual %0d", $time, got);
            fails++;
         end else begin
            want = medians_due.pop_front();
            if (got !== want) begin
               $display("%0t: median mismatch, expected %0d, actual %0d", $time, want, got);
               fails++;
            end
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic signed [31:0] req_sample;
   logic              rsp_valid;
   logic              rsp_stall;
   logic signed [31:0] rsp_median;
   logic              csr_wr_en;
   logic [6:0]        csr_wr_data;

   median_scoreboard medians = new();
   bit               steady = 1'b0;   // no idling on either side while set
   int unsigned      medians_seen = 0;
   int unsigned      holdoff_left = 0;
   bit               held = 1'b0;

   sliding_window_median dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_median  (rsp_median),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Result side: check each transfer, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         medians.check_median(rsp_median);
         medians_seen++;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else if (!held && medians_seen >= 25) begin
         // one long hold-off so the block backs up into its input
         held         = 1'b1;
         holdoff_left = 150;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < 12);
      end
   end

   // One sample transfer, with random idle cycles ahead of it
   task automatic send_sample(input sample_type v);
      while (!steady && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= v;
      do @(posedge clock); while (req_stall);
      medians.take_sample(v);
   endtask

   // Write window_size once the block has drained
   task automatic write_window(input logic [6:0] v);
      req_valid <= 1'b0;
      while (medians.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      medians.set_window(v);
   endtask

   // Mostly full-range values, some extremes, some narrow values for ties
   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7FFFFFFF;
               1: return 32'sh80000000;
               2: return 32'sh0;
               default: return -32'sd1;
            endcase
         end
         1, 2: return sample_type'(int'($urandom_range(0, 16)) - 8);
         default: return sample_type'($urandom());
      endcase
   endfunction

   initial begin
      sample_type  edge_vals [20] = '{
         32'sh7FFFFFFF, 32'sh80000000, 32'sh0, -32'sd1, 32'sd1,
         32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh80000000,
         32'sd5, 32'sd5, 32'sd5, -32'sd5, 32'sd3,
         32'sd3, 32'sh55555555, 32'shAAAAAAAA, 32'sd7, -32'sd7};
      int unsigned phase_win [8] = '{1, 64, 0, 127, 2, 65, 5, 1};
      int unsigned phase_len [8] = '{30, 130, 25, 90, 40, 70, 40, 30};
      int unsigned p;
      int unsigned n;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_sample  <= '0;
      rsp_stall   <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes and ties at the reset window size
      foreach (edge_vals[i]) send_sample(edge_vals[i]);

      // Random phases over several window sizes, the extremes among them
      phase_win[7] = $urandom_range(1, 16);
      for (p = 0; p < 8; p++) begin
         write_window(7'(phase_win[p]));
         steady = (p == 1);
         for (n = 0; n < phase_len[p]; n++) send_sample(pick_sample());
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      while (medians.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (medians.fails == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Run limit
   initial begin
      #1000000;
      $display("simulation failed");
      $finish;
   end

endmodule
